[sv/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

[sv/ssc_pkg.sv]
`default_nettype none
package ssc_pkg;
	localparam int RW    = 20;  // radius
	localparam int HW    = 21;  // depth, up to 2r
	localparam int DENW  = 22;  // 3r - h
	localparam int CW    = 32;
	localparam int VW    = 31;
	localparam int QW    = 24;  // quotient bits of the centroid offset
	localparam int NUMW  = 45;
	localparam int DIVW  = 24;
	localparam int REMW  = 25;
	localparam int PW    = 62;
	localparam int KW    = 32;
	localparam int PRODW = 94;
	localparam logic [KW-1:0] PI_THIRD_Q31 = 32'd2248839617;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic [HW-1:0]        h;
		logic [HW-1:0]        d;
		logic [DENW-1:0]      den;
		logic                 sub;
	} item_t;
endpackage
`default_nettype wire

[sv/sphere_submerged_cap_volume_top.sv]
// fully pipelined: front reg, queue, multiply stages, divider, output register
// throughput: one beat per cycle unless stalled, set by the multiply and divider chain
// the divider spends one stage per quotient bit (24 stages)
// arst_n clears all valid state and sets radius to 1.0 (65536)
`default_nettype none
module sphere_submerged_cap_volume_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [19:0]       cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic signed [31:0] center_z,
	input  wire logic signed [31:0] fluid_level,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [30:0]            submerged_volume,
	output logic signed [31:0]     centroid_x,
	output logic signed [31:0]     centroid_y,
	output logic signed [31:0]     centroid_z,
	output logic                   is_submerged
);
	import ssc_pkg::*;

	logic [RW-1:0] radius_q;
	logic  f_valid, f_ready, b_valid, b_ready;
	item_t f_item, b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 20'd65536;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	ssc_front u_front (
		.clk, .arst_n, .radius(radius_q),
		.in_valid, .in_ready, .center_x, .center_y, .center_z, .fluid_level,
		.itm_valid(f_valid), .itm_ready(f_ready), .itm(f_item)
	);

	ssc_queue u_queue (
		.clk, .arst_n,
		.push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
	);

	ssc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.itm_valid(b_valid), .itm_ready(b_ready), .itm(b_item),
		.out_valid, .out_ready, .submerged_volume, .centroid_x, .centroid_y,
		.centroid_z, .is_submerged
	);
endmodule
`default_nettype wire

[sv/ssc_front.sv]
`default_nettype none
module ssc_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [ssc_pkg::RW-1:0]   radius,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [31:0]       center_x,
	input  wire logic signed [31:0]       center_y,
	input  wire logic signed [31:0]       center_z,
	input  wire logic signed [31:0]       fluid_level,
	output logic                          itm_valid,
	input  wire logic                     itm_ready,
	output ssc_pkg::item_t                itm
);
	import ssc_pkg::*;

	logic signed [33:0] hs;
	logic [HW-1:0]      r2;
	logic [DENW-1:0]    r3;
	logic [HW-1:0]      h;
	item_t              nxt;
	item_t              itm_s1;
	logic               vld_s1;

	always_comb begin
		hs = $signed({{2{fluid_level[31]}}, fluid_level}) - $signed({{2{center_z[31]}}, center_z})
			+ $signed({14'b0, radius});
		r2 = {radius, 1'b0};
		r3 = {2'b0, radius} + {1'b0, radius, 1'b0};
		// clamp to the full diameter
		if (hs > $signed({13'b0, r2}))
			h = r2;
		else
			h = hs[HW-1:0];
		nxt.cx  = center_x;
		nxt.cy  = center_y;
		nxt.cz  = center_z;
		nxt.sub = !hs[33] && (hs != 34'sd0);
		nxt.h   = h;
		nxt.d   = r2 - h;
		nxt.den = r3 - {1'b0, h};
	end

	assign in_ready  = !vld_s1 || itm_ready;
	assign itm_valid = vld_s1;
	assign itm       = itm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (itm_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

[sv/ssc_queue.sv]
`default_nettype none
`include "assert_macros.svh"
module ssc_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire ssc_pkg::item_t push_item,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output ssc_pkg::item_t pop_item
);
	import ssc_pkg::*;

	item_t      mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'(QDEPTH));
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > 2'(QDEPTH))
	`ASSERT_HOLDS(a_ptr_gap, clk, arst_n,
		(cnt_q == 2'd0 || cnt_q == 2'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
endmodule
`default_nettype wire

[sv/ssc_back.sv]
`default_nettype none
`include "assert_macros.svh"
module ssc_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              itm_valid,
	output logic                   itm_ready,
	input  wire ssc_pkg::item_t    itm,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [30:0]            submerged_volume,
	output logic signed [31:0]     centroid_x,
	output logic signed [31:0]     centroid_y,
	output logic signed [31:0]     centroid_z,
	output logic                   is_submerged
);
	import ssc_pkg::*;

	localparam int SHIFT = 31 + 2 * FRAC_BITS;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic                 sub;
	} pay_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [QW-1:0]   nlow;
		logic [QW-1:0]   quo;
		logic [DIVW-1:0] dvs;
		logic [VW-1:0]   vol;
		pay_t            pay;
	} dv_t;

	logic en;

	pay_t pay_s1, pay_s2, pay_s3, pay_s4, pay_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2*HW-1:0]   hsq_s1, dsq_s1;
	logic [DENW-1:0]   den_s1;
	logic [PW-1:0]     p_s2;
	logic [NUMW-1:0]   num_s2, num_s3, num_s4, num_s5;
	logic [DIVW-1:0]   div_s2, div_s3, div_s4, div_s5;
	logic [62:0]       pplo_s3, pphi_s3;
	logic [PRODW-1:0]  prod_s4;
	logic [VW-1:0]     vol_s5;

	logic [63:0]       p_full;
	logic [PRODW:0]    rsum;
	logic [PRODW:0]    vfull;

	dv_t  dv_s  [QW+1];
	logic dvv_s [QW+1];

	logic              vld_out_q;
	logic [VW-1:0]     vol_out_q;
	logic signed [CW-1:0] cx_out_q, cy_out_q, cz_out_q;
	logic              sub_out_q;
	logic signed [32:0] czd;
	logic signed [CW-1:0] cz_sat;

	assign en        = !vld_out_q || out_ready;
	assign itm_ready = en;

	assign p_full = hsq_s1 * den_s1;

	always_comb begin
		rsum  = {1'b0, prod_s4} + ((PRODW+1)'(1) << (SHIFT - 1));
		vfull = rsum >> SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= itm_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= '{cx: itm.cx, cy: itm.cy, cz: itm.cz, sub: itm.sub};
			hsq_s1 <= itm.h * itm.h;
			dsq_s1 <= itm.d * itm.d;
			den_s1 <= itm.den;

			pay_s2 <= pay_s1;
			p_s2   <= p_full[PW-1:0];
			num_s2 <= {3'b0, dsq_s1} + {2'b0, dsq_s1, 1'b0} + {22'b0, den_s1, 1'b0};
			div_s2 <= {den_s1, 2'b00};

			// split multiply by pi/3
			pay_s3  <= pay_s2;
			pplo_s3 <= p_s2[30:0] * PI_THIRD_Q31;
			pphi_s3 <= p_s2[61:31] * PI_THIRD_Q31;
			num_s3  <= num_s2;
			div_s3  <= div_s2;

			pay_s4  <= pay_s3;
			prod_s4 <= {31'b0, pplo_s3} + {pphi_s3, 31'b0};
			num_s4  <= num_s3;
			div_s4  <= div_s3;

			pay_s5 <= pay_s4;
			vol_s5 <= (|vfull[PRODW:VW]) ? {VW{1'b1}} : vfull[VW-1:0];
			num_s5 <= num_s4;
			div_s5 <= div_s4;
		end
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		dv_s[0].rem  = {4'b0, num_s5[NUMW-1:QW]};
		dv_s[0].nlow = num_s5[QW-1:0];
		dv_s[0].quo  = '0;
		dv_s[0].dvs  = div_s5;
		dv_s[0].vol  = vol_s5;
		dv_s[0].pay  = pay_s5;
		dvv_s[0]     = vld_s5;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [REMW-1:0] trial;
		logic            ge;
		dv_t             nxt;
		always_comb begin
			trial    = {dv_s[k].rem[REMW-2:0], dv_s[k].nlow[QW-1]};
			ge       = trial >= {1'b0, dv_s[k].dvs};
			nxt      = dv_s[k];
			nxt.rem  = ge ? trial - {1'b0, dv_s[k].dvs} : trial;
			nxt.nlow = {dv_s[k].nlow[QW-2:0], 1'b0};
			nxt.quo  = {dv_s[k].quo[QW-2:0], ge};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else if (en) begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		czd = $signed({dv_s[QW].pay.cz[31], dv_s[QW].pay.cz}) - $signed({9'b0, dv_s[QW].quo});
		if (czd[32] != czd[31])
			cz_sat = {1'b1, 31'b0};
		else
			cz_sat = czd[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_out_q <= dvv_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sub_out_q <= dv_s[QW].pay.sub;
			if (dv_s[QW].pay.sub) begin
				vol_out_q <= dv_s[QW].vol;
				cx_out_q  <= dv_s[QW].pay.cx;
				cy_out_q  <= dv_s[QW].pay.cy;
				cz_out_q  <= (dv_s[QW].vol != '0) ? cz_sat : '0;
			end else begin
				vol_out_q <= '0;
				cx_out_q  <= '0;
				cy_out_q  <= '0;
				cz_out_q  <= '0;
			end
		end
	end

	assign out_valid        = vld_out_q;
	assign submerged_volume = vol_out_q;
	assign centroid_x       = cx_out_q;
	assign centroid_y       = cy_out_q;
	assign centroid_z       = cz_out_q;
	assign is_submerged     = sub_out_q;

	`ASSERT_HOLDS(a_dry_zero, clk, arst_n,
		(vld_out_q && !sub_out_q) |-> (vol_out_q == '0 && cx_out_q == '0 && cz_out_q == '0))
	`ASSERT_HOLDS(a_novol_noz, clk, arst_n,
		(vld_out_q && vol_out_q == '0) |-> (cz_out_q == '0))
	`ASSERT_HOLDS(a_hold_on_stall, clk, arst_n,
		(vld_out_q && !out_ready) |=> (vld_out_q && $stable(vol_out_q) && $stable(cz_out_q)))
endmodule
`default_nettype wire
